>>> rtl/bernstein_basis_sampler_top_macros.svh
// Assertion macros used by the sampler RTL (bbs_serial).
`ifndef BERNSTEIN_BASIS_SAMPLER_TOP_MACROS_SVH
`define BERNSTEIN_BASIS_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define BBS_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");

// Next-cycle implication, quiet during reset.
`define BBS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

>>> rtl/bbs_pkg.sv
// Types, constants and helpers of the Bernstein basis sampler.
package bbs_pkg;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam int unsigned TAB_N = 13;

  typedef enum logic [1:0] {
    REG_DEGREE = 2'd0,
    REG_MIN_T  = 2'd1,
    REG_MAX_T  = 2'd2,
    REG_COUNT  = 2'd3
  } reg_idx_t;

  // Clamped configuration as the datapath sees it.
  typedef struct packed {
    logic [3:0]  n;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [10:0] den;
  } cfg_t;

  typedef logic [TAB_N-1:0][TAB_N-1:0][9:0] binom_tab_t;

  function automatic binom_tab_t make_binom();
    binom_tab_t tab;
    tab = '0;
    for (int i = 0; i < TAB_N; i++) begin
      tab[i][0] = 10'd1;
      for (int j = 1; j < TAB_N; j++) begin
        if (i > 0) tab[i][j] = tab[i-1][j-1] + tab[i-1][j];
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM = make_binom();

  // Q1.16 product with round to nearest; operands never exceed one.
  function automatic logic [16:0] mul_q16(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b) + 34'd32768;
    return p[32:16];
  endfunction

endpackage

>>> rtl/bbs_cfg.sv
// APB register file with clamping of the configuration.
module bbs_cfg import bbs_pkg::*; #(
  parameter int MAX_DEGREE  = 8,
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  localparam logic [3:0]  NMAX   = 4'(MAX_DEGREE);
  localparam logic [10:0] CNTMAX = (MAX_SAMPLES > 2047) ? 11'd2047 : 11'(MAX_SAMPLES);

  logic [3:0]  degree;
  logic [16:0] min_t;
  logic [16:0] max_t;
  logic [10:0] sample_count;
  reg_idx_t    sel;
  logic [10:0] cnt;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      degree       <= 4'd3;
      min_t        <= 17'd0;
      max_t        <= ONE_Q16;
      sample_count <= 11'd64;
    end else if (psel && penable && pwrite && pready) begin
      case (sel)
        REG_DEGREE: degree       <= pwdata[3:0];
        REG_MIN_T:  min_t        <= pwdata[16:0];
        REG_MAX_T:  max_t        <= pwdata[16:0];
        REG_COUNT:  sample_count <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DEGREE: prdata = {28'd0, degree};
      REG_MIN_T:  prdata = {15'd0, min_t};
      REG_MAX_T:  prdata = {15'd0, max_t};
      REG_COUNT:  prdata = {21'd0, sample_count};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.n  = (degree == 4'd0) ? 4'd1 : ((degree > NMAX) ? NMAX : degree);
    cfg.lo = (min_t > ONE_Q16) ? ONE_Q16 : min_t;
    cfg.hi = (max_t > ONE_Q16) ? ONE_Q16 : max_t;
    cnt    = (sample_count < 11'd2) ? 11'd2
           : ((sample_count > CNTMAX) ? CNTMAX : sample_count);
    cfg.den = cnt - 11'd1;
  end

endmodule

>>> rtl/bbs_point.sv
// Sample point pipeline: scale the index, divide one bit a stage, offset.
module bbs_point import bbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  sample_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] t,
  output logic [16:0] u
);

  localparam int QW = 17;
  localparam int NW = 28;
  localparam int NS = QW + 3;

  logic          v   [0:NS-1];
  logic          rdy [0:NS];
  logic [10:0]   idx;
  logic [16:0]   diff;
  logic [NW-1:0] rem [0:QW];
  logic [QW-1:0] q   [0:QW];
  logic [17:0]   tsum;
  logic          up;
  logic [10:0]   idx_c;

  assign up       = cfg.hi >= cfg.lo;
  assign in_ready = rdy[0];
  assign rdy[NS]  = out_ready;
  assign out_valid = v[NS-1];
  assign idx_c    = ({1'b0, sample_index} > cfg.den) ? cfg.den : {1'b0, sample_index};

  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  // stage 0: clamp index, take the span
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (rdy[0]) v[0] <= in_valid;
    if (rdy[0] && in_valid) begin
      idx  <= idx_c;
      diff <= up ? (cfg.hi - cfg.lo) : (cfg.lo - cfg.hi);
    end
  end

  // stage 1: numerator plus half the divisor
  always_ff @(posedge clk) begin
    if (rst) v[1] <= 1'b0;
    else if (rdy[1]) v[1] <= v[0];
    if (rdy[1] && v[0]) begin
      rem[0] <= NW'(idx) * NW'(diff) + NW'(cfg.den >> 1);
      q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [NW-1:0] trial;
    assign trial = NW'(cfg.den) << (QW - k);
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else if (rdy[k+1]) v[k+1] <= v[k];
      if (rdy[k+1] && v[k]) begin
        if (rem[k-1] >= trial) begin
          rem[k] <= rem[k-1] - trial;
          q[k]   <= {q[k-1][QW-2:0], 1'b1};
        end else begin
          rem[k] <= rem[k-1];
          q[k]   <= {q[k-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign tsum = up ? (18'(cfg.lo) + 18'(q[QW])) : (18'(cfg.lo) - 18'(q[QW]));

  always_ff @(posedge clk) begin
    if (rst) v[NS-1] <= 1'b0;
    else if (rdy[NS-1]) v[NS-1] <= v[NS-2];
    if (rdy[NS-1] && v[NS-2]) begin
      if (tsum > 18'(ONE_Q16)) begin
        t <= ONE_Q16;
        u <= 17'd0;
      end else begin
        t <= tsum[16:0];
        u <= ONE_Q16 - tsum[16:0];
      end
    end
  end

endmodule

>>> rtl/bbs_power.sv
// Power chains of t and 1-t, one power a stage, then the basis lanes.
module bbs_power import bbs_pkg::*; #(
  parameter int MAX_DEGREE = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [16:0]                t,
  input  logic [16:0]                u,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [MAX_DEGREE:0][16:0]  vals
);

  localparam int MD = MAX_DEGREE;
  localparam int NS = MD + 3;

  logic        v    [0:NS-1];
  logic        rdy  [0:NS];
  logic [16:0] pt   [0:MD][0:MD];
  logic [16:0] rq   [0:MD][0:MD];
  logic [16:0] tcur [0:MD];
  logic [16:0] ucur [0:MD];
  logic [16:0] qcur [0:MD];
  logic [33:0] prod [0:MD];
  logic [43:0] sum  [0:MD];

  assign in_ready  = rdy[0];
  assign rdy[NS]   = out_ready;
  assign out_valid = v[NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (rdy[0]) v[0] <= in_valid;
    if (rdy[0] && in_valid) begin
      tcur[0] <= t;
      ucur[0] <= u;
      qcur[0] <= ONE_Q16;
      for (int i = 0; i <= MD; i++) begin
        pt[0][i] <= ONE_Q16;
        rq[0][i] <= ONE_Q16;
      end
    end
  end

  // rq holds Q(n-j) at slot j, so each lane reads a fixed slot
  for (genvar k = 1; k <= MD; k++) begin : g_pow
    logic [16:0] newp;
    logic [16:0] newq;
    assign newp = mul_q16(pt[k-1][k-1], tcur[k-1]);
    assign newq = mul_q16(qcur[k-1], ucur[k-1]);
    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (rdy[k]) v[k] <= v[k-1];
      if (rdy[k] && v[k-1]) begin
        tcur[k] <= tcur[k-1];
        ucur[k] <= ucur[k-1];
        qcur[k] <= newq;
        for (int i = 0; i <= MD; i++) begin
          pt[k][i] <= (i == k) ? newp : pt[k-1][i];
          rq[k][i] <= ((5'(i) + 5'(k)) == {1'b0, cfg.n}) ? newq : rq[k-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v[MD+1] <= 1'b0;
    else if (rdy[MD+1]) v[MD+1] <= v[MD];
    if (rdy[MD+1] && v[MD]) begin
      for (int j = 0; j <= MD; j++) prod[j] <= 34'(pt[MD][j]) * 34'(rq[MD][j]);
    end
  end

  for (genvar j = 0; j <= MD; j++) begin : g_val
    assign sum[j] = 44'(BINOM[cfg.n][j]) * 44'(prod[j]) + 44'd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) v[MD+2] <= 1'b0;
    else if (rdy[MD+2]) v[MD+2] <= v[MD+1];
    if (rdy[MD+2] && v[MD+1]) begin
      for (int j = 0; j <= MD; j++) begin
        vals[j] <= (sum[j][43:16] > 28'(ONE_Q16)) ? ONE_Q16 : sum[j][32:16];
      end
    end
  end

endmodule

>>> rtl/bbs_serial.sv
// Holds one sample's basis values and emits them in order of j.
module bbs_serial import bbs_pkg::*; #(
  parameter int MAX_DEGREE = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MAX_DEGREE:0][16:0]  vals,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3:0]                 basis_index,
  output logic [16:0]                basis_value,
  output logic                       last
);

  `include "bernstein_basis_sampler_top_macros.svh"

  localparam int IW = (MAX_DEGREE < 1) ? 1 : $clog2(MAX_DEGREE + 1);

  logic                      full;
  logic [3:0]                cnt;
  logic [MAX_DEGREE:0][16:0] hold;
  logic                      fire;

  assign last        = cnt == cfg.n;
  assign fire        = out_valid && out_ready;
  assign in_ready    = !full || (fire && last);
  assign out_valid   = full;
  assign basis_index = cnt;
  assign basis_value = hold[cnt[IW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      cnt  <= 4'd0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
      cnt  <= 4'd0;
    end else if (fire) begin
      if (last) full <= 1'b0;
      else cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hold <= vals;
  end

  `BBS_ASSERT_IMPL(a_cnt_in_range, clk, rst, full, cnt <= cfg.n)
  `BBS_ASSERT_NEXT(a_advance, clk, rst, fire && !last,
                   out_valid && basis_index == $past(basis_index) + 4'd1)
  `BBS_ASSERT_NEXT(a_load_restart, clk, rst, in_valid && in_ready,
                   out_valid && basis_index == 4'd0)

endmodule

>>> rtl/bernstein_basis_sampler_top.sv
// Top level of the Bernstein basis sampler.
//   channel   | signals                                  | moves
//   cfg (APB) | psel penable pwrite paddr pwdata prdata  | register write / read
//   in        | in_valid in_ready sample_index           | one sample request
//   out       | out_valid out_ready basis_index ...      | one basis value, last on j = n
// Each request yields n+1 results (n is the clamped degree), one per cycle while out_ready
// is high; the serialiser at the tail sets the sustained rate.
// The point pipeline has 17 divider stages; the power pipeline computes one power per stage.
// Reset (rst, synchronous) empties every stage and restores register defaults.
// A stall on out holds every occupied stage; bubbles close up behind the stalled stage.
module bernstein_basis_sampler_top import bbs_pkg::*; #(
  parameter int MAX_DEGREE  = 8,
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  sample_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  basis_index,
  output logic [16:0] basis_value,
  output logic        last
);

  cfg_t                      cfg;
  logic                      pt_valid;
  logic                      pt_ready;
  logic [16:0]               t;
  logic [16:0]               u;
  logic                      pw_valid;
  logic                      pw_ready;
  logic [MAX_DEGREE:0][16:0] vals;

  bbs_cfg #(.MAX_DEGREE(MAX_DEGREE), .MAX_SAMPLES(MAX_SAMPLES)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bbs_point u_point (
    .clk, .rst, .cfg, .in_valid, .in_ready, .sample_index,
    .out_valid(pt_valid), .out_ready(pt_ready), .t, .u
  );

  bbs_power #(.MAX_DEGREE(MAX_DEGREE)) u_power (
    .clk, .rst, .cfg, .in_valid(pt_valid), .in_ready(pt_ready), .t, .u,
    .out_valid(pw_valid), .out_ready(pw_ready), .vals
  );

  bbs_serial #(.MAX_DEGREE(MAX_DEGREE)) u_serial (
    .clk, .rst, .cfg, .in_valid(pw_valid), .in_ready(pw_ready), .vals,
    .out_valid, .out_ready, .basis_index, .basis_value, .last
  );

endmodule
